### rtl/fvbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvbm_pkg: shared constants for the forward-vector to basis-matrix block.
// Default widths and the lane count of the three vector components.
// ----------------------------------------------------------------------------
package fvbm_pkg;

    // Default direction component width and output fraction bits.
    localparam int DEF_IN_WIDTH  = 16;
    localparam int DEF_FRAC_BITS = 14;

    // One lane for each of x, y and z.
    localparam int LANES = 3;

endpackage

### rtl/forward_vector_to_basis_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forward_vector_to_basis_matrix: look-at basis from one direction vector.
// Normalises a signed vector to forward f and forms right = (fy, -fx, 0) and
// up = (-fx*fz, -fy*fz, fx*fx + fy*fy), in fixed point, signed but for up z.
// ----------------------------------------------------------------------------
// The block takes one item in every cycle unless a stall on the result side
// holds the whole pipeline, and returns its matrix through stages A, B, C,
// the search stages, U and O. The normalisation finds each rounded forward
// component one bit a stage over FRAC_BITS + 1 stages of shift-and-add
// compares, with three lanes working side by side.
// A zero-length input sets the zero_length flag in m_tuser and returns zeros.
module forward_vector_to_basis_matrix #(
    parameter int IN_WIDTH  = fvbm_pkg::DEF_IN_WIDTH,
    parameter int FRAC_BITS = fvbm_pkg::DEF_FRAC_BITS
) (
    input  logic aclk,
    input  logic aresetn,
    // dir_x, dir_y, dir_z from bit 0 upwards.
    input  logic [((3*IN_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic s_tvalid,
    output logic s_tready,
    // fwd_x, fwd_y, fwd_z, right_x, right_y, right_z, up_x, up_y, up_z
    // from bit 0 upwards.
    output logic [((8*FRAC_BITS+16+7)/8)*8-1:0] m_tdata,
    // zero_length.
    output logic m_tuser,
    output logic m_tvalid,
    input  logic m_tready
);
    import fvbm_pkg::*;

    localparam int OW   = FRAC_BITS + 2;
    localparam int NW   = FRAC_BITS + 1;
    localparam int SQW  = 2 * IN_WIDTH;
    localparam int LW   = SQW + 2;
    localparam int EW   = SQW + 2 * FRAC_BITS + 7;
    localparam int PW   = LW + FRAC_BITS + 4;
    localparam int NS   = FRAC_BITS + 1;
    localparam int MW   = 2 * NW;
    localparam int DATW = 8 * FRAC_BITS + 16;
    localparam int TDW  = ((DATW + 7) / 8) * 8;
    localparam logic [NW-1:0] ONE_FX = NW'(1) << FRAC_BITS;

    // The whole pipeline advances whenever the output register can move.
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Stage A: registered input item.
    logic                       a_vld_reg;
    logic signed [IN_WIDTH-1:0] a_d_reg [LANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < LANES; i++) begin
                a_d_reg[i] <= s_tdata[i*IN_WIDTH +: IN_WIDTH];
            end
        end
    end

    // Stage B: magnitudes, signs and squares.
    logic                b_vld_reg;
    logic                b_zero_reg;
    logic                b_sgn_reg [LANES];
    logic [SQW-1:0]      b_sq_reg  [LANES];
    logic [IN_WIDTH-1:0] a_mag     [LANES];

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            a_mag[i] = a_d_reg[i][IN_WIDTH-1] ? IN_WIDTH'(-a_d_reg[i]) : a_d_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (en) begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_zero_reg <= (a_d_reg[0] == '0) && (a_d_reg[1] == '0) && (a_d_reg[2] == '0);
            for (int i = 0; i < LANES; i++) begin
                b_sgn_reg[i] <= a_d_reg[i][IN_WIDTH-1];
                b_sq_reg[i]  <= SQW'(a_mag[i]) * SQW'(a_mag[i]);
            end
        end
    end

    // Search state: index 0 is the start point, index k+1 after bit FRAC_BITS-k.
    logic                 s_vld_reg  [NS+1];
    logic                 s_zero_reg [NS+1];
    logic [LW-1:0]        s_len_reg  [NS+1];
    logic                 s_sgn_reg  [NS+1][LANES];
    logic [NW-1:0]        s_n_reg    [NS+1][LANES];
    logic signed [EW-1:0] s_e_reg    [NS+1][LANES];
    logic signed [PW-1:0] s_p_reg    [NS+1][LANES];

    // Stage C: squared length, residual 4*m^2*2^(2F) - len2, and P = -len2.
    logic [LW-1:0] b_len;
    assign b_len = LW'(b_sq_reg[0]) + LW'(b_sq_reg[1]) + LW'(b_sq_reg[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_vld_reg[0] <= 1'b0;
        end else if (en) begin
            s_vld_reg[0] <= b_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_zero_reg[0] <= b_zero_reg;
            s_len_reg[0]  <= b_len;
            for (int i = 0; i < LANES; i++) begin
                s_sgn_reg[0][i] <= b_sgn_reg[i];
                s_n_reg[0][i]   <= '0;
                s_e_reg[0][i]   <= $signed(EW'(b_sq_reg[i]) << (2 * FRAC_BITS + 2))
                                   - $signed(EW'(b_len));
                s_p_reg[0][i]   <= -$signed(PW'(b_len));
            end
        end
    end

    // Search stages: try one bit of each rounded component per stage.
    for (genvar k = 0; k < NS; k++) begin : g_search
        localparam int B = FRAC_BITS - k;
        logic [NW-1:0]        c_n  [LANES];
        logic signed [EW-1:0] t_e  [LANES];
        logic                 take [LANES];

        always_comb begin
            for (int i = 0; i < LANES; i++) begin
                c_n[i]  = s_n_reg[k][i] | (NW'(1) << B);
                t_e[i]  = s_e_reg[k][i]
                          - (EW'(s_p_reg[k][i]) <<< (B + 2))
                          - $signed(EW'(s_len_reg[k]) << (2 * B + 2));
                take[i] = (c_n[i] <= ONE_FX) && !t_e[i][EW-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                s_vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                s_vld_reg[k+1] <= s_vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                s_zero_reg[k+1] <= s_zero_reg[k];
                s_len_reg[k+1]  <= s_len_reg[k];
                for (int i = 0; i < LANES; i++) begin
                    s_sgn_reg[k+1][i] <= s_sgn_reg[k][i];
                    if (take[i]) begin
                        s_n_reg[k+1][i] <= c_n[i];
                        s_e_reg[k+1][i] <= t_e[i];
                        s_p_reg[k+1][i] <= s_p_reg[k][i]
                                           + $signed(PW'(s_len_reg[k]) << (B + 1));
                    end else begin
                        s_n_reg[k+1][i] <= s_n_reg[k][i];
                        s_e_reg[k+1][i] <= s_e_reg[k][i];
                        s_p_reg[k+1][i] <= s_p_reg[k][i];
                    end
                end
            end
        end
    end

    // Stage U: magnitude products for the up vector.
    logic          u_vld_reg;
    logic          u_zero_reg;
    logic          u_sgn_reg [LANES];
    logic [NW-1:0] u_n_reg   [LANES];
    logic [MW-1:0] u_pxz_reg, u_pyz_reg, u_sxx_reg, u_syy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_vld_reg <= 1'b0;
        end else if (en) begin
            u_vld_reg <= s_vld_reg[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u_zero_reg <= s_zero_reg[NS];
            for (int i = 0; i < LANES; i++) begin
                u_sgn_reg[i] <= s_sgn_reg[NS][i];
                u_n_reg[i]   <= s_n_reg[NS][i];
            end
            u_pxz_reg <= MW'(s_n_reg[NS][0]) * MW'(s_n_reg[NS][2]);
            u_pyz_reg <= MW'(s_n_reg[NS][1]) * MW'(s_n_reg[NS][2]);
            u_sxx_reg <= MW'(s_n_reg[NS][0]) * MW'(s_n_reg[NS][0]);
            u_syy_reg <= MW'(s_n_reg[NS][1]) * MW'(s_n_reg[NS][1]);
        end
    end

    // Stage O: rounding, signs, saturation and the zero-vector override.
    logic [MW:0]          half_rnd;
    logic [OW-1:0]        r_x, r_y;
    logic [MW:0]          uz_sum;
    logic [NW-1:0]        uz;
    logic signed [OW-1:0] f_val [LANES];
    logic [DATW-1:0]      o_data;

    assign half_rnd = (MW + 1)'(1) << (FRAC_BITS - 1);

    always_comb begin
        r_x    = OW'(((MW + 1)'(u_pxz_reg) + half_rnd) >> FRAC_BITS);
        r_y    = OW'(((MW + 1)'(u_pyz_reg) + half_rnd) >> FRAC_BITS);
        uz_sum = ((MW + 1)'(u_sxx_reg) + (MW + 1)'(u_syy_reg) + half_rnd) >> FRAC_BITS;
        uz     = (uz_sum > (MW + 1)'(ONE_FX)) ? ONE_FX : NW'(uz_sum);
        for (int i = 0; i < LANES; i++) begin
            f_val[i] = u_sgn_reg[i] ? -$signed({1'b0, u_n_reg[i]})
                                    : $signed({1'b0, u_n_reg[i]});
        end
        o_data = {uz,
                  (u_sgn_reg[1] != u_sgn_reg[2]) ? r_y : OW'(-r_y),
                  (u_sgn_reg[0] != u_sgn_reg[2]) ? r_x : OW'(-r_x),
                  1'b0,
                  OW'(-f_val[0]),
                  f_val[1],
                  f_val[2],
                  f_val[1],
                  f_val[0]};
        if (u_zero_reg) begin
            o_data = '0;
        end
    end

    logic            o_vld_reg;
    logic [TDW-1:0]  o_data_reg;
    logic            o_zero_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_vld_reg <= 1'b0;
        end else if (en) begin
            o_vld_reg <= u_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o_data_reg <= TDW'(o_data);
            o_zero_reg <= u_zero_reg;
        end
    end

    assign m_tvalid = o_vld_reg;
    assign m_tdata  = o_data_reg;
    assign m_tuser  = o_zero_reg;

    // A zero-length item carries an all-zero matrix.
    a_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("zero-length item with non-zero matrix");

    // Right x always repeats forward y.
    a_right_x: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3*OW +: OW] == m_tdata[OW +: OW]))
        else $error("right x differs from forward y");

    // Up z never exceeds 1.0.
    a_up_z_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7*OW+1 +: NW] <= ONE_FX))
        else $error("up z above 1.0");

    // A stalled result stays put until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule
